// File: design/llrp_pkg.sv
// Shared types and constants for the laser line row peak extractor.
// No dependencies; imported by every design module.
package llrp_pkg;

	localparam int unsigned BOXES_MAX = 3;
	localparam int unsigned STEP_MAX = 16;
	localparam int unsigned COL_W = 12;
	localparam int unsigned ROW_W = 12;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned BOUNDS_W = 48;
	localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

	localparam logic [BOUNDS_W-1:0] BOX0_RESET = 48'd38849673651455;
	localparam logic [BOUNDS_W-1:0] BOX1_RESET = 48'd38849673641210;
	localparam logic [BOUNDS_W-1:0] BOX2_RESET = 48'd38848499228310;
	localparam logic [CNT_W-1:0] MIN_ROWS_RESET = 13'd400;
	localparam logic [4:0] STEP_RESET = 5'd1;

	typedef enum logic [2:0] {
		REG_BOX0 = 3'd0,
		REG_BOX1 = 3'd1,
		REG_BOX2 = 3'd2,
		REG_MIN_ROWS = 3'd3,
		REG_ROW_STEP = 3'd4,
		REG_FRAME_STEP = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic active;
		logic searched;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} frame_state_t;

	typedef struct packed {
		logic go;
		logic active;
		logic searched;
		logic rend;
		logic fend;
		logic [COL_W-1:0] col;
	} box_cmd_t;

	typedef struct packed {
		logic found;
		logic [COL_W-1:0] col;
		logic enough;
	} box_res_t;

	// 0 acts as 1, above 16 acts as 16
	function automatic logic [4:0] clamp_step(input logic [4:0] s);
		logic [4:0] r;
		if (s == 5'd0) begin
			r = 5'd1;
		end else if (s > 5'd16) begin
			r = 5'd16;
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

// File: design/llrp_frame_ctl.sv
// Frame phase, row and column counters, and row search selection.
// Depends on llrp_pkg.
module llrp_frame_ctl #(
	parameter int unsigned COL_LAST = 4095,
	parameter int unsigned ROW_LAST = 4095
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic                  rend,
	input  logic                  fend,
	input  logic [4:0]            row_step,
	input  logic [4:0]            frame_step,
	output llrp_pkg::frame_state_t st
);
	import llrp_pkg::*;

	logic [3:0] phase_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [3:0] mod_q [STEP_MAX];
	logic [4:0] fstep;
	logic [4:0] rsel;
	logic [4:0] phase_inc;
	logic [3:0] phase_next;

	assign fstep = clamp_step(frame_step);
	assign rsel = clamp_step(row_step) - 5'd1;
	assign phase_inc = {1'b0, phase_q} + 5'd1;
	assign phase_next = (phase_inc >= fstep) ? 4'd0 : phase_inc[3:0];

	assign st.active = (phase_q == 4'd0);
	assign st.searched = (mod_q[rsel[3:0]] == 4'd0);
	assign st.row = row_q;
	assign st.col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			row_q <= '0;
			col_q <= '0;
			for (int k = 0; k < STEP_MAX; k++) mod_q[k] <= '0;
		end else if (go && fend) begin
			phase_q <= phase_next;
			row_q <= '0;
			col_q <= '0;
			for (int k = 0; k < STEP_MAX; k++) mod_q[k] <= '0;
		end else if (go && st.active) begin
			if (rend) begin
				col_q <= '0;
				if (row_q < ROW_W'(ROW_LAST)) begin
					row_q <= row_q + 1'b1;
					for (int k = 0; k < STEP_MAX; k++) begin
						mod_q[k] <= (mod_q[k] == 4'(k)) ? 4'd0 : mod_q[k] + 4'd1;
					end
				end
			end else if (col_q < COL_W'(COL_LAST)) begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// File: design/llrp_box_track.sv
// One threshold box: in-box test, running row peak and per-frame row count.
// Depends on llrp_pkg.
module llrp_box_track (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [llrp_pkg::BOUNDS_W-1:0]       bounds,
	input  logic [llrp_pkg::CNT_W-1:0]          min_rows,
	input  logic [7:0]                          hue,
	input  logic [7:0]                          saturation,
	input  logic [7:0]                          brightness,
	input  llrp_pkg::box_cmd_t                  cmd,
	output llrp_pkg::box_res_t                  res
);
	import llrp_pkg::*;

	logic [7:0] best_q;
	logic [COL_W-1:0] best_col_q;
	logic seen_q;
	logic [CNT_W-1:0] rows_q;
	logic [CNT_W-1:0] rows_next;
	logic in_box;
	logic hit;
	logic found;
	logic [COL_W-1:0] col_now;

	assign in_box = (hue >= bounds[47:40]) && (hue <= bounds[39:32]) &&
		(saturation >= bounds[31:24]) && (saturation <= bounds[23:16]) &&
		(brightness >= bounds[15:8]) && (brightness <= bounds[7:0]);
	assign hit = cmd.searched && in_box && (brightness > best_q);
	assign col_now = hit ? cmd.col : best_col_q;
	assign found = cmd.searched && (seen_q || hit);
	assign rows_next = (found && rows_q != COUNT_MAX) ? rows_q + 1'b1 : rows_q;

	assign res.found = found;
	assign res.col = found ? col_now : '0;
	assign res.enough = (rows_next >= min_rows);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			best_col_q <= '0;
			seen_q <= 1'b0;
			rows_q <= '0;
		end else if (cmd.go) begin
			if (cmd.active) begin
				if (cmd.rend) begin
					best_q <= '0;
					best_col_q <= '0;
					seen_q <= 1'b0;
					rows_q <= cmd.fend ? '0 : rows_next;
				end else if (hit) begin
					best_q <= brightness;
					best_col_q <= cmd.col;
					seen_q <= 1'b1;
				end
			end else if (cmd.fend) begin
				best_q <= '0;
				best_col_q <= '0;
				seen_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/laser_line_row_peak_extractor.sv
// Laser line row peak extractor: input register, per-box peak trackers, result register.
// A row result passes the input register, then the result register. Throughput: 1 pixel
// per cycle, set by the single compare-and-update pass, unless a stalled result holds input.
// A stalled result holds only pixels that end a row; other pixels keep flowing.
// Reset (arst_n low) restores default registers and clears counters, peaks and valids.
// Depends on llrp_pkg, llrp_frame_ctl, llrp_box_track.
module laser_line_row_peak_extractor #(
	parameter int unsigned MAX_COLUMNS = 4096,
	parameter int unsigned MAX_ROWS = 4096,
	parameter int unsigned BOX_COUNT = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_index,
	input  logic [llrp_pkg::BOUNDS_W-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       hue,
	input  logic [7:0]                       saturation,
	input  logic [7:0]                       brightness,
	input  logic                             row_end,
	input  logic                             frame_end,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [llrp_pkg::ROW_W-1:0]       row_index,
	output logic [llrp_pkg::COL_W-1:0]       peak_col_0,
	output logic                             found_0,
	output logic [llrp_pkg::COL_W-1:0]       peak_col_1,
	output logic                             found_1,
	output logic [llrp_pkg::COL_W-1:0]       peak_col_2,
	output logic                             found_2,
	output logic [1:0]                       chosen_box,
	output logic                             enough_rows,
	output logic                             last_of_frame
);
	import llrp_pkg::*;

	localparam int unsigned COL_LAST = (MAX_COLUMNS < 4096) ? MAX_COLUMNS - 1 : 4095;
	localparam int unsigned ROW_LAST = (MAX_ROWS < 4096) ? MAX_ROWS - 1 : 4095;

	logic [BOUNDS_W-1:0] bounds_q [BOXES_MAX];
	logic [CNT_W-1:0] min_rows_q;
	logic [4:0] row_step_q;
	logic [4:0] frame_step_q;

	logic s1_valid_q;
	logic [7:0] hue_s1, sat_s1, bri_s1;
	logic rend_s1, fend_s1;

	logic out_valid_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q [BOXES_MAX];
	logic [BOXES_MAX-1:0] found_q;
	logic [1:0] chosen_q;
	logic enough_q;
	logic last_q;

	frame_state_t st;
	box_cmd_t cmd;
	box_res_t res [BOXES_MAX];
	logic out_free, makes_result, go, in_acc;
	logic [1:0] chosen;
	logic enough;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounds_q[0] <= BOX0_RESET;
			bounds_q[1] <= BOX1_RESET;
			bounds_q[2] <= BOX2_RESET;
			min_rows_q <= MIN_ROWS_RESET;
			row_step_q <= STEP_RESET;
			frame_step_q <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX0: bounds_q[0] <= cfg_data;
				REG_BOX1: bounds_q[1] <= cfg_data;
				REG_BOX2: bounds_q[2] <= cfg_data;
				REG_MIN_ROWS: min_rows_q <= cfg_data[CNT_W-1:0];
				REG_ROW_STEP: row_step_q <= cfg_data[4:0];
				REG_FRAME_STEP: frame_step_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign makes_result = st.active && rend_s1;
	assign go = s1_valid_q && (!makes_result || out_free);
	assign in_stall = s1_valid_q && !go;
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hue_s1 <= hue;
			sat_s1 <= saturation;
			bri_s1 <= brightness;
			rend_s1 <= row_end | frame_end;
			fend_s1 <= frame_end;
		end
	end

	llrp_frame_ctl #(
		.COL_LAST(COL_LAST),
		.ROW_LAST(ROW_LAST)
	) u_frame_ctl (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.rend(rend_s1),
		.fend(fend_s1),
		.row_step(row_step_q),
		.frame_step(frame_step_q),
		.st(st)
	);

	assign cmd.go = go;
	assign cmd.active = st.active;
	assign cmd.searched = st.searched;
	assign cmd.rend = rend_s1;
	assign cmd.fend = fend_s1;
	assign cmd.col = st.col;

	for (genvar k = 0; k < BOXES_MAX; k++) begin : g_box
		if (k < BOX_COUNT) begin : g_on
			llrp_box_track u_box (
				.clk(clk),
				.arst_n(arst_n),
				.bounds(bounds_q[k]),
				.min_rows(min_rows_q),
				.hue(hue_s1),
				.saturation(sat_s1),
				.brightness(bri_s1),
				.cmd(cmd),
				.res(res[k])
			);
		end else begin : g_off
			assign res[k] = '0;
		end
	end

	// frame verdict: first box with enough rows, else the last box
	always_comb begin
		chosen = 2'(BOX_COUNT - 1);
		enough = 1'b0;
		for (int k = BOX_COUNT - 1; k >= 0; k--) begin
			if (res[k].enough) begin
				chosen = 2'(k);
				enough = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && makes_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && makes_result) begin
			row_q <= st.row;
			for (int k = 0; k < BOXES_MAX; k++) begin
				col_q[k] <= res[k].col;
				found_q[k] <= res[k].found;
			end
			chosen_q <= fend_s1 ? chosen : 2'd0;
			enough_q <= fend_s1 & enough;
			last_q <= fend_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_q;
	assign peak_col_0 = col_q[0];
	assign found_0 = found_q[0];
	assign peak_col_1 = col_q[1];
	assign found_1 = found_q[1];
	assign peak_col_2 = col_q[2];
	assign found_2 = found_q[2];
	assign chosen_box = chosen_q;
	assign enough_rows = enough_q;
	assign last_of_frame = last_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q && out_valid_q)
		else $error("input stalled without a blocked result");

	a_verdict_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_frame |-> chosen_box == 2'd0 && !enough_rows)
		else $error("frame verdict on a row that is not the last");

	a_chosen_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chosen_box != 2'd3)
		else $error("chosen box out of range");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule

// File: test/testbench.sv
// Self-checking testbench for laser_line_row_peak_extractor: streams HSV pixel frames,
// predicts every row result and compares it field by field with what the block returns.
// Depends on llrp_pkg and the design files under design/.
module testbench;
	import llrp_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD = 400;
	localparam int LAST_INDEX = 4095;
	localparam int HIT_MAX = 8191;

	typedef struct packed {
		logic [7:0] h;
		logic [7:0] s;
		logic [7:0] v;
		logic re;
		logic fe;
	} pixel_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [2:0][COL_W-1:0] col;
		logic [2:0] found;
		logic [1:0] chosen;
		logic enough;
		logic last;
	} row_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [BOUNDS_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] hue = '0;
	logic [7:0] saturation = '0;
	logic [7:0] brightness = '0;
	logic row_end = 1'b0;
	logic frame_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ROW_W-1:0] row_index;
	logic [COL_W-1:0] peak_col_0, peak_col_1, peak_col_2;
	logic found_0, found_1, found_2;
	logic [1:0] chosen_box;
	logic enough_rows;
	logic last_of_frame;

	laser_line_row_peak_extractor uut (.*);

	// register copies
	logic [BOUNDS_W-1:0] box_lim [3];
	logic [CNT_W-1:0] min_rows;
	logic [4:0] row_step_r, frame_step_r;

	// tracked block state
	int phase, row_no, col_no;
	logic [7:0] best_v [3];
	int best_col [3];
	bit seen [3];
	int rows_hit [3];

	pixel_t pending [$];
	row_result_t rows_due [$];
	pixel_t px_now;
	int px_queued = 0;
	int px_accepted = 0;
	bit px_taken = 1'b0;
	bit row_taken = 1'b0;
	int quiet = 0;
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int eff_step(input logic [4:0] s);
		if (s == 0) return 1;
		if (s > 16) return 16;
		return int'(s);
	endfunction

	function automatic bit hits(input logic [47:0] b, input pixel_t p);
		return p.h >= b[47:40] && p.h <= b[39:32] && p.s >= b[31:24] && p.s <= b[23:16]
			&& p.v >= b[15:8] && p.v <= b[7:0];
	endfunction

	function automatic void clear_row();
		for (int k = 0; k < 3; k++) begin
			best_v[k] = '0;
			best_col[k] = 0;
			seen[k] = 1'b0;
		end
		col_no = 0;
	endfunction

	task automatic track_pixel(input pixel_t p);
		row_result_t r;
		bit rend, searched;
		int fstep, rstep;
		rend = p.re || p.fe;
		fstep = eff_step(frame_step_r);
		rstep = eff_step(row_step_r);
		if (phase != 0) begin
			if (p.fe) begin
				phase = (phase + 1 >= fstep) ? 0 : phase + 1;
				row_no = 0;
				clear_row();
			end
			return;
		end
		searched = (row_no % rstep) == 0;
		if (searched) begin
			for (int k = 0; k < 3; k++) begin
				if (hits(box_lim[k], p) && p.v > best_v[k]) begin
					best_v[k] = p.v;
					best_col[k] = col_no;
					seen[k] = 1'b1;
				end
			end
		end
		if (!rend) begin
			if (col_no < LAST_INDEX) col_no++;
			return;
		end
		r = '0;
		r.row = ROW_W'(row_no);
		for (int k = 0; k < 3; k++) begin
			if (searched && seen[k]) begin
				r.col[k] = COL_W'(best_col[k]);
				r.found[k] = 1'b1;
				if (rows_hit[k] < HIT_MAX) rows_hit[k]++;
			end
		end
		if (p.fe) begin
			r.chosen = 2'd2;
			for (int k = 2; k >= 0; k--) begin
				if (rows_hit[k] >= min_rows) begin
					r.chosen = 2'(k);
					r.enough = 1'b1;
				end
			end
			r.last = 1'b1;
			phase = (phase + 1 >= fstep) ? 0 : phase + 1;
			row_no = 0;
			for (int k = 0; k < 3; k++) rows_hit[k] = 0;
		end else if (row_no < LAST_INDEX) begin
			row_no++;
		end
		clear_row();
		rows_due = {rows_due, r};
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	task automatic check_row();
		row_result_t want, got;
		got.row = row_index;
		got.col = {peak_col_2, peak_col_1, peak_col_0};
		got.found = {found_2, found_1, found_0};
		got.chosen = chosen_box;
		got.enough = enough_rows;
		got.last = last_of_frame;
		if (rows_due.size() == 0) begin
			report("row_index of unexpected result", 32'(got.row), 0);
			return;
		end
		want = rows_due.pop_front();
		if (got.row !== want.row) report("row_index", 32'(got.row), 32'(want.row));
		for (int k = 0; k < 3; k++) begin
			if (got.col[k] !== want.col[k])
				report($sformatf("peak_col_%0d", k), 32'(got.col[k]), 32'(want.col[k]));
			if (got.found[k] !== want.found[k])
				report($sformatf("found_%0d", k), 32'(got.found[k]), 32'(want.found[k]));
		end
		if (got.chosen !== want.chosen)
			report("chosen_box", 32'(got.chosen), 32'(want.chosen));
		if (got.enough !== want.enough)
			report("enough_rows", 32'(got.enough), 32'(want.enough));
		if (got.last !== want.last)
			report("last_of_frame", 32'(got.last), 32'(want.last));
	endtask

	// monitor and watchdog
	always @(posedge clk) begin
		px_taken = arst_n && in_valid && !in_stall;
		row_taken = arst_n && out_valid && !out_stall;
		if (px_taken) begin
			track_pixel({hue, saturation, brightness, row_end, frame_end});
			px_accepted++;
		end
		if (row_taken) check_row();
		if (px_taken || row_taken || !arst_n) quiet = 0;
		else quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// pixel driver
	always @(negedge clk) begin
		if (!in_valid || px_taken) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				px_now = pending.pop_front();
				hue <= px_now.h;
				saturation <= px_now.s;
				brightness <= px_now.v;
				row_end <= px_now.re;
				frame_end <= px_now.fe;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_served != hold_asked) begin
			hold_served++;
			hold_left = LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic queue_px(input pixel_t p);
		pending = {pending, p};
		px_queued++;
	endtask

	task automatic wait_drained();
		while (px_accepted != px_queued || rows_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [BOUNDS_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_BOX0, REG_BOX1, REG_BOX2: box_lim[int'(idx)] = val;
			REG_MIN_ROWS: min_rows = val[CNT_W-1:0];
			REG_ROW_STEP: row_step_r = val[4:0];
			REG_FRAME_STEP: frame_step_r = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup_regs(input logic [47:0] b0, input logic [47:0] b1,
			input logic [47:0] b2, input int mr, input int rs, input int fs);
		write_reg(REG_BOX0, b0);
		write_reg(REG_BOX1, b1);
		write_reg(REG_BOX2, b2);
		write_reg(REG_MIN_ROWS, BOUNDS_W'(mr));
		write_reg(REG_ROW_STEP, BOUNDS_W'(rs));
		write_reg(REG_FRAME_STEP, BOUNDS_W'(fs));
	endtask

	function automatic logic [7:0] pick(input logic [7:0] lo, input logic [7:0] hi,
			input int top);
		int l, u;
		l = int'(lo);
		u = (int'(hi) > top) ? top : int'(hi);
		if (l > u) return 8'($urandom_range(top, 0));
		case ($urandom_range(3))
			0: return 8'(l);
			1: return 8'(u);
			default: return 8'($urandom_range(u, l));
		endcase
	endfunction

	function automatic pixel_t rand_px();
		pixel_t p;
		int k;
		k = $urandom_range(2);
		if ($urandom_range(9) < 7) begin
			p.h = pick(box_lim[k][47:40], box_lim[k][39:32], 179);
			p.s = pick(box_lim[k][31:24], box_lim[k][23:16], 255);
			p.v = pick(box_lim[k][15:8], box_lim[k][7:0], 255);
		end else begin
			p.h = 8'($urandom_range(179));
			p.s = 8'($urandom_range(255));
			p.v = 8'($urandom_range(255));
		end
		p.re = 1'b0;
		p.fe = 1'b0;
		return p;
	endfunction

	function automatic logic [47:0] rand_box();
		logic [47:0] b;
		int a, c, t;
		b = 48'h00FF_00FF_00FF;
		case ($urandom_range(5))
			0: ;
			1: begin
				t = $urandom_range(2);
				a = $urandom_range(255, 1);
				c = $urandom_range(a - 1, 0);
				b[t*16 +: 16] = {a[7:0], c[7:0]};
			end
			2: b = $urandom_range(1) ? 48'h0 : {48{1'b1}};
			default: begin
				for (int ch = 0; ch < 3; ch++) begin
					a = $urandom_range(255);
					c = $urandom_range(255);
					if (a > c) begin
						t = a;
						a = c;
						c = t;
					end
					b[ch*16 +: 16] = {a[7:0], c[7:0]};
				end
			end
		endcase
		return b;
	endfunction

	function automatic int rand_step();
		case ($urandom_range(9))
			0: return 0;
			1: return 16;
			2: return $urandom_range(31, 17);
			3: return $urandom_range(15, 3);
			default: return $urandom_range(2, 1);
		endcase
	endfunction

	function automatic int rand_min_rows();
		case ($urandom_range(7))
			0: return 0;
			1: return 4096;
			default: return $urandom_range(8, 1);
		endcase
	endfunction

	task automatic add_frame(input int rows, input int max_cols);
		pixel_t p;
		int n;
		for (int r = 0; r < rows; r++) begin
			n = $urandom_range(max_cols, 1);
			for (int c = 0; c < n; c++) begin
				p = rand_px();
				p.re = (c == n - 1);
				p.fe = (r == rows - 1) && (c == n - 1);
				if (p.fe && $urandom_range(7) == 0) p.re = 1'b0;
				queue_px(p);
			end
		end
	endtask

	task automatic add_noise(input int n);
		pixel_t p;
		for (int i = 0; i < n; i++) begin
			p = rand_px();
			p.re = ($urandom_range(3) == 0);
			p.fe = ($urandom_range(19) == 0);
			queue_px(p);
		end
	endtask

	task automatic run_segment(input int seg);
		int start;
		setup_regs(rand_box(), rand_box(), rand_box(), rand_min_rows(), rand_step(),
			rand_step());
		@(posedge clk);
		send_idle_pct = (seg < 6) ? 37 : (seg < 12) ? 82 : 0;
		stall_pct = (seg < 6) ? 82 : (seg < 12) ? 37 : 0;
		start = px_queued;
		while (px_queued - start < 70) begin
			if ($urandom_range(9) == 0) add_noise(8);
			else add_frame($urandom_range(8, 1), $urandom_range(12, 1));
		end
		if (seg == 3 || seg == 14) hold_asked++;
		wait_drained();
	endtask

	initial begin
		box_lim[0] = BOX0_RESET;
		box_lim[1] = BOX1_RESET;
		box_lim[2] = BOX2_RESET;
		min_rows = MIN_ROWS_RESET;
		row_step_r = STEP_RESET;
		frame_step_r = STEP_RESET;
		phase = 0;
		row_no = 0;
		for (int k = 0; k < 3; k++) rows_hit[k] = 0;
		clear_row();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 37;
		stall_pct = 82;

		// default boxes: zero brightness, ties, hue top, bound edges, frame end alone
		queue_px({8'd60, 8'd200, 8'd0, 2'b00});
		queue_px({8'd60, 8'd200, 8'd120, 2'b00});
		queue_px({8'd60, 8'd200, 8'd120, 2'b00});
		queue_px({8'd179, 8'd255, 8'd255, 2'b00});
		queue_px({8'd60, 8'd255, 8'd255, 2'b10});
		queue_px({8'd35, 8'd100, 8'd100, 2'b00});
		queue_px({8'd85, 8'd255, 8'd255, 2'b00});
		queue_px({8'd0, 8'd0, 8'd0, 2'b10});
		queue_px({8'd90, 8'd0, 8'd30, 2'b00});
		queue_px({8'd50, 8'd40, 8'd200, 2'b01});
		queue_px({8'd128, 8'd128, 8'd128, 2'b11});
		wait_drained();

		// full, empty and all-zero boxes; unsearched rows; skipped frames
		setup_regs(48'h00FF_00FF_00FF, 48'hC80A_00FF_00FF, 48'h0, 0, 2, 3);
		@(posedge clk);
		queue_px({8'd10, 8'd20, 8'd30, 2'b00});
		queue_px({8'd100, 8'd20, 8'd40, 2'b10});
		queue_px({8'd100, 8'd200, 8'd250, 2'b10});
		queue_px({8'd170, 8'd1, 8'd0, 2'b01});
		queue_px({8'd10, 8'd10, 8'd10, 2'b10});
		queue_px({8'd10, 8'd10, 8'd10, 2'b01});
		queue_px({8'd1, 8'd1, 8'd1, 2'b11});
		queue_px({8'd20, 8'd20, 8'd20, 2'b11});
		wait_drained();

		for (int seg = 0; seg < 18; seg++) run_segment(seg);

		repeat (8) @(negedge clk);
		if (rows_due.size() != 0) report("results never delivered", 0, rows_due.size());
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: laser_line_row_peak_extractor.f
design/llrp_pkg.sv
design/llrp_frame_ctl.sv
design/llrp_box_track.sv
design/laser_line_row_peak_extractor.sv
test/testbench.sv
